/* rtl/core/tsoe_pkg.sv */
// Shared types, constants and codes of the tolerant set-operation engine.
`default_nettype none

package tsoe_pkg;

    localparam int VALUE_W         = 64;
    localparam int TOL_W           = 33;
    localparam int COUNT_W         = 9;
    localparam int DIFF_W          = VALUE_W + 2;
    localparam int REFERENCE_DEPTH = 256;
    localparam int RESULT_DEPTH    = 256;
    localparam int GROUP_SIZE      = 16;
    localparam int OUT_DATA_W      = 88;

    // 1e-9 in Q32.32 is about 4.29 LSBs, rounded up.
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(5);

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_OPERAND = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_UNION        = 2'd0,
        MODE_INTERSECTION = 2'd1,
        MODE_DIFFERENCE   = 2'd2
    } mode_t;

    typedef enum logic {
        REG_OP_MODE   = 1'b0,
        REG_TOLERANCE = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_RED,
        ST_DEC
    } state_t;

    // Store control handed from the sequencer to a chain of cells.
    typedef struct packed {
        logic clear;
        logic append;
    } chain_ctrl_t;

    // Match window: a difference d matches when neg < d < pos.
    typedef struct packed {
        logic [DIFF_W-1:0] pos;
        logic [DIFF_W-1:0] neg;
    } tol_t;

endpackage

`default_nettype wire

/* rtl/core/tsoe_cell.sv */
// One store cell: holds an entry, shifts it on append and compares it with the query.
`default_nettype none

module tsoe_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tsoe_pkg::chain_ctrl_t          ctrl,
    input  wire logic [tsoe_pkg::VALUE_W-1:0]   prev_value,
    input  wire logic                           prev_valid,
    input  wire logic [tsoe_pkg::VALUE_W-1:0]   query,
    input  wire tsoe_pkg::tol_t                 tol,
    output logic [tsoe_pkg::VALUE_W-1:0]        value,
    output logic                                valid,
    output logic                                match
);

    logic [tsoe_pkg::VALUE_W-1:0] value_reg;
    logic                         valid_reg;
    logic                         match_reg;
    logic [tsoe_pkg::DIFF_W-1:0]  diff;
    logic                         hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.append) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.append) begin
            value_reg <= prev_value;
        end
        match_reg <= hit;
    end

    // Sign-extended difference cannot overflow, so the window test is exact.
    assign diff = {{2{query[tsoe_pkg::VALUE_W-1]}}, query}
                - {{2{value_reg[tsoe_pkg::VALUE_W-1]}}, value_reg};
    assign hit  = valid_reg
               && ($signed(diff) < $signed(tol.pos))
               && ($signed(diff) > $signed(tol.neg));

    assign value = value_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

/* rtl/core/tsoe_chain.sv */
// A row of store cells with a registered OR tree that reports any match.
`default_nettype none

module tsoe_chain #(
    parameter int DEPTH = tsoe_pkg::REFERENCE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tsoe_pkg::chain_ctrl_t          ctrl,
    input  wire logic [tsoe_pkg::VALUE_W-1:0]   append_value,
    input  wire logic [tsoe_pkg::VALUE_W-1:0]   query,
    input  wire tsoe_pkg::tol_t                 tol,
    output logic                                found
);

    localparam int GROUP  = tsoe_pkg::GROUP_SIZE;
    localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

    logic [tsoe_pkg::VALUE_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]             cell_valid;
    logic [NGROUP*GROUP-1:0]      match_pad;
    logic [NGROUP-1:0]            grp_reg;
    logic                         found_reg;

    // The unused tail of the last group only exists when the depth is not a whole
    // number of groups.
    if (NGROUP*GROUP > DEPTH) begin : g_pad
        assign match_pad[NGROUP*GROUP-1:DEPTH] = '0;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            tsoe_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .prev_value (append_value),
                .prev_valid (1'b1),
                .query      (query),
                .tol        (tol),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .match      (match_pad[i])
            );
        end else begin : g_body
            tsoe_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .prev_value (cell_value[i-1]),
                .prev_valid (cell_valid[i-1]),
                .query      (query),
                .tol        (tol),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .match      (match_pad[i])
            );
        end
    end

    // Two registered levels: groups of cells, then the groups.
    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_reg[g] <= |match_pad[g*GROUP +: GROUP];
        end
        found_reg <= |grp_reg;
    end

    assign found = found_reg;

endmodule

`default_nettype wire

/* rtl/core/tolerant_set_operation_engine_unit.sv */
// Top level of the tolerant set-operation engine: sequencer, counters and stream ports.
//
// Usage: write op_mode (index 0) and match_tolerance (index 1) on the cfg channel while
// the engine is idle. Items arrive on the s_ channel with the command in s_tuser: clear
// empties both stores, load appends s_tdata to the reference store, and operand tests
// s_tdata against the stores and produces one transfer on the m_ channel. s_tlast marks
// the final operand and comes back as m_tlast. Clear and load produce nothing. An operand
// passes through these steps before the next input transfer: a compare in every store
// cell, two levels of the registered match tree, a decide step that appends and loads
// the output register (and waits while that register is still occupied), and a return
// to idle, in which s_tready is high again.
// Each store is a row of cells that shift their entries along on every append.
// The output register holds a finished result while the next item is taken; if it is
// still occupied when the following operand is decided, the engine waits until the
// receiver takes it. Reset empties both stores and clears the overflow flag, restores
// op_mode to union and match_tolerance to 5 LSBs. No clearing pass is needed.
`default_nettype none

module tolerant_set_operation_engine_unit #(
    parameter int REFERENCE_DEPTH = tsoe_pkg::REFERENCE_DEPTH,
    parameter int RESULT_DEPTH    = tsoe_pkg::RESULT_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,   // [63:0] value
    input  wire logic [1:0]                     s_tuser,   // [1:0] cmd
    input  wire logic                           s_tlast,   // last_element
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [63:0] out_value, [64] included, [73:65] position, [82:74] result_count,
    // [83] overflow, [87:84] zero
    output logic [tsoe_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast,   // done_res
    // Configuration writes.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [tsoe_pkg::TOL_W-1:0]     cfg_data
);

    localparam int REF_CNT_W = $clog2(REFERENCE_DEPTH + 1);
    localparam int RES_CNT_W = $clog2(RESULT_DEPTH + 1);
    localparam int VW        = tsoe_pkg::VALUE_W;
    localparam int CW        = tsoe_pkg::COUNT_W;
    localparam int DW        = tsoe_pkg::DIFF_W;

    tsoe_pkg::state_t       state_reg, state_next;
    logic [1:0]             mode_reg, mode_next;
    tsoe_pkg::tol_t         tol_reg, tol_next;
    logic [REF_CNT_W-1:0]   ref_count_reg, ref_count_next;
    logic [RES_CNT_W-1:0]   res_count_reg, res_count_next;
    logic                   ovf_reg, ovf_next;
    logic [VW-1:0]          query_reg;
    logic                   last_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [VW-1:0]          out_value_reg;
    logic                   out_incl_reg;
    logic [CW-1:0]          out_pos_reg, out_count_reg;
    logic                   out_last_reg, out_ovf_reg;
    logic                   out_load;

    tsoe_pkg::chain_ctrl_t  ref_ctrl, res_ctrl;
    logic                   ref_found, res_found;
    logic                   in_xfer, cfg_xfer, out_free;
    logic                   keep, incl;
    logic [RES_CNT_W+CW-1:0] pos_wide, count_wide;

    assign s_tready  = (state_reg == tsoe_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || m_tready;

    // Configuration registers; the negated bound is kept ready for the cells.
    always_comb begin
        mode_next = mode_reg;
        tol_next  = tol_reg;
        if (cfg_xfer) begin
            case (tsoe_pkg::reg_index_t'(cfg_index))
                tsoe_pkg::REG_OP_MODE: begin
                    mode_next = cfg_data[1:0];
                end
                tsoe_pkg::REG_TOLERANCE: begin
                    tol_next.pos = {{(DW-tsoe_pkg::TOL_W){1'b0}}, cfg_data};
                    tol_next.neg = DW'(0) - {{(DW-tsoe_pkg::TOL_W){1'b0}}, cfg_data};
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Decision for the operand in flight.
    always_comb begin
        case (tsoe_pkg::mode_t'(mode_reg))
            tsoe_pkg::MODE_UNION:        keep = 1'b1;
            tsoe_pkg::MODE_INTERSECTION: keep = ref_found;
            tsoe_pkg::MODE_DIFFERENCE:   keep = !ref_found;
            default:                     keep = 1'b0;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        ref_count_next = ref_count_reg;
        res_count_next = res_count_reg;
        ovf_next       = ovf_reg;
        ref_ctrl       = '0;
        res_ctrl       = '0;
        incl           = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            tsoe_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (tsoe_pkg::cmd_t'(s_tuser))
                        tsoe_pkg::CMD_CLEAR: begin
                            ref_count_next = '0;
                            res_count_next = '0;
                            ovf_next       = 1'b0;
                            ref_ctrl.clear = 1'b1;
                            res_ctrl.clear = 1'b1;
                        end
                        tsoe_pkg::CMD_LOAD: begin
                            if (ref_count_reg < REF_CNT_W'(REFERENCE_DEPTH)) begin
                                ref_ctrl.append = 1'b1;
                                ref_count_next  = ref_count_reg + REF_CNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        tsoe_pkg::CMD_OPERAND: begin
                            state_next = tsoe_pkg::ST_CMP;
                        end
                        default: begin
                            state_next = tsoe_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tsoe_pkg::ST_CMP: state_next = tsoe_pkg::ST_GRP;
            tsoe_pkg::ST_GRP: state_next = tsoe_pkg::ST_RED;
            tsoe_pkg::ST_RED: state_next = tsoe_pkg::ST_DEC;
            tsoe_pkg::ST_DEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = tsoe_pkg::ST_IDLE;
                    if (keep && !res_found) begin
                        if (res_count_reg < RES_CNT_W'(RESULT_DEPTH)) begin
                            incl            = 1'b1;
                            res_ctrl.append = 1'b1;
                            res_count_next  = res_count_reg + RES_CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            default: state_next = tsoe_pkg::ST_IDLE;
        endcase
    end

    assign pos_wide   = {{CW{1'b0}}, res_count_reg};
    assign count_wide = {{CW{1'b0}}, res_count_next};

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tsoe_pkg::ST_IDLE;
            mode_reg      <= tsoe_pkg::MODE_UNION;
            tol_reg.pos   <= {{(DW-tsoe_pkg::TOL_W){1'b0}}, tsoe_pkg::TOL_RESET};
            tol_reg.neg   <= DW'(0) - {{(DW-tsoe_pkg::TOL_W){1'b0}}, tsoe_pkg::TOL_RESET};
            ref_count_reg <= '0;
            res_count_reg <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            tol_reg       <= tol_next;
            ref_count_reg <= ref_count_next;
            res_count_reg <= res_count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            query_reg <= s_tdata;
            last_reg  <= s_tlast;
        end
        if (out_load) begin
            out_value_reg <= query_reg;
            out_incl_reg  <= incl;
            out_pos_reg   <= incl ? pos_wide[CW-1:0] : '0;
            out_count_reg <= count_wide[CW-1:0];
            out_last_reg  <= last_reg;
            out_ovf_reg   <= ovf_next;
        end
    end

    tsoe_chain #(
        .DEPTH (REFERENCE_DEPTH)
    ) u_ref_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ref_ctrl),
        .append_value (s_tdata),
        .query        (query_reg),
        .tol          (tol_reg),
        .found        (ref_found)
    );

    tsoe_chain #(
        .DEPTH (RESULT_DEPTH)
    ) u_res_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (res_ctrl),
        .append_value (query_reg),
        .query        (query_reg),
        .tol          (tol_reg),
        .found        (res_found)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_ovf_reg, out_count_reg, out_pos_reg, out_incl_reg,
                       out_value_reg};

    a_ref_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ref_count_reg <= REF_CNT_W'(REFERENCE_DEPTH))
        else $error("reference count exceeds store depth");

    a_res_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_count_reg <= RES_CNT_W'(RESULT_DEPTH))
        else $error("result count exceeds store depth");

    a_operand_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tuser == tsoe_pkg::CMD_OPERAND) |=> state_reg == tsoe_pkg::ST_CMP)
        else $error("operand transfer did not start a compare");

    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == tsoe_pkg::ST_DEC))
        else $error("result appeared outside the decide step");

    a_position_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_incl_reg) |-> (out_pos_reg + CW'(1)) == out_count_reg)
        else $error("included position disagrees with result count");

endmodule

`default_nettype wire

/* verif/tb_tolerant_set_operation_engine_unit.sv */
// Self-checking testbench for the tolerant set-operation engine with a built-in predictor.
`timescale 1ns / 1ps

module tb_tolerant_set_operation_engine_unit;

    localparam logic [1:0]  CMD_IGNORED   = 2'd3;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [63:0] VAL_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN       = 64'h8000_0000_0000_0000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          POOL_SIZE     = 64;
    localparam longint      LIMIT_NS      = 5_000_000;

    typedef struct packed {
        logic [63:0]                  value;
        logic                         included;
        logic [tsoe_pkg::COUNT_W-1:0] position;
        logic [tsoe_pkg::COUNT_W-1:0] count;
        logic                         done;
        logic                         overflow;
    } set_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [63:0]                     s_tdata;
    logic [1:0]                      s_tuser;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tsoe_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_index;
    logic [tsoe_pkg::TOL_W-1:0]      cfg_data;

    // Shadow copy of the engine state.
    logic [1:0]                 mode_reg;
    logic [tsoe_pkg::TOL_W-1:0] tol_reg;
    logic [63:0]                ref_entries [tsoe_pkg::REFERENCE_DEPTH];
    logic [63:0]                set_entries [tsoe_pkg::RESULT_DEPTH];
    int                         ref_count;
    int                         set_count;
    bit                         overflow_flag;

    set_result_t      expected_set_results [$];
    logic [63:0]      value_pool [$];
    int               mismatch_count;
    bit               src_no_gaps;
    bit               sink_no_stall;
    set_result_t      got;
    set_result_t      want;

    tolerant_set_operation_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got_v, want_v, $realtime);
        mismatch_count++;
    endtask

    // The difference is taken in the order that keeps it non-negative, so it never wraps.
    function automatic bit near_match(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] abs_diff;
        if ($signed(a) >= $signed(b))
            abs_diff = a - b;
        else
            abs_diff = b - a;
        return abs_diff < 64'(tol_reg);
    endfunction

    function automatic bit found_near(input bit in_set_store, input logic [63:0] v);
        int n;
        n = in_set_store ? set_count : ref_count;
        for (int i = 0; i < n; i++) begin
            if (near_match(in_set_store ? set_entries[i] : ref_entries[i], v))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void apply_set_item(input logic [1:0] cmd, input logic [63:0] v,
                                           input logic last);
        bit          keep;
        set_result_t r;
        case (cmd)
            tsoe_pkg::CMD_CLEAR: begin
                ref_count     = 0;
                set_count     = 0;
                overflow_flag = 1'b0;
            end
            tsoe_pkg::CMD_LOAD: begin
                if (ref_count < tsoe_pkg::REFERENCE_DEPTH) begin
                    ref_entries[ref_count] = v;
                    ref_count++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            tsoe_pkg::CMD_OPERAND: begin
                case (mode_reg)
                    tsoe_pkg::MODE_UNION:        keep = 1'b1;
                    tsoe_pkg::MODE_INTERSECTION: keep = found_near(1'b0, v);
                    tsoe_pkg::MODE_DIFFERENCE:   keep = !found_near(1'b0, v);
                    default:                     keep = 1'b0;
                endcase
                r.value    = v;
                r.included = 1'b0;
                r.position = '0;
                if (keep && !found_near(1'b1, v)) begin
                    if (set_count < tsoe_pkg::RESULT_DEPTH) begin
                        r.included             = 1'b1;
                        r.position             = tsoe_pkg::COUNT_W'(set_count);
                        set_entries[set_count] = v;
                        set_count++;
                    end else begin
                        overflow_flag = 1'b1;
                    end
                end
                r.count    = tsoe_pkg::COUNT_W'(set_count);
                r.done     = last;
                r.overflow = overflow_flag;
                expected_set_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Mostly values close to earlier ones, so that matches near the tolerance edge occur.
    function automatic logic [63:0] pick_value();
        logic [63:0] base;
        logic [63:0] off;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 25 || value_pool.size() == 0)
            return {$urandom, $urandom};
        if (r < 38) begin
            case ($urandom_range(0, 2))
                0:       return VAL_MIN + 64'($urandom_range(0, 3));
                1:       return VAL_MAX - 64'($urandom_range(0, 3));
                default: return 64'($signed($urandom_range(0, 8)) - 4);
            endcase
        end
        base = value_pool[$urandom_range(0, value_pool.size() - 1)];
        case ($urandom_range(0, 2))
            0:       off = 64'($urandom_range(0, 3));
            1:       off = (tol_reg == '0) ? 64'($urandom_range(0, 2))
                                           : 64'(tol_reg) + 64'($urandom_range(0, 2)) - 64'd1;
            default: off = {31'b0, 1'($urandom_range(0, 1)), $urandom};
        endcase
        return $urandom_range(0, 1) ? base + off : base - off;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [63:0] v, input logic last);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (src_no_gaps || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= cmd;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        apply_set_item(cmd, v, last);
        value_pool.push_back(v);
        if (value_pool.size() > POOL_SIZE)
            void'(value_pool.pop_front());
    endtask

    // Clear and load give no result, so a few extra cycles cover any item still in flight.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_set_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input tsoe_pkg::reg_index_t idx,
                             input logic [tsoe_pkg::TOL_W-1:0] data);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == tsoe_pkg::REG_OP_MODE)
            mode_reg = data[1:0];
        else
            tol_reg = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver side: runs of ready and stall, mostly short.
    initial begin : sink_pacing
        int  run_len;
        bit  run_ready;
        run_len   = 0;
        run_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (run_len == 0) begin
                if (sink_no_stall || $urandom_range(0, 99) < 65) begin
                    run_ready = 1'b1;
                    run_len   = $urandom_range(1, 8);
                end else begin
                    run_ready = 1'b0;
                    run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                            : $urandom_range(1, 3);
                end
            end
            run_len--;
            m_tready <= run_ready;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.value    = m_tdata[63:0];
            got.included = m_tdata[64];
            got.position = m_tdata[73:65];
            got.count    = m_tdata[82:74];
            got.overflow = m_tdata[83];
            got.done     = m_tlast;
            if (expected_set_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected", got.value, '0);
            end else begin
                want = expected_set_results.pop_front();
                if (got.value !== want.value)
                    report_mismatch("out_value", got.value, want.value);
                if (got.included !== want.included)
                    report_mismatch("included", 64'(got.included), 64'(want.included));
                if (got.position !== want.position)
                    report_mismatch("position", 64'(got.position), 64'(want.position));
                if (got.count !== want.count)
                    report_mismatch("result_count", 64'(got.count), 64'(want.count));
                if (got.done !== want.done)
                    report_mismatch("done_res", 64'(got.done), 64'(want.done));
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
            end
        end
    end

    // Starts from the reset configuration: union with a tolerance of 5 LSBs.
    task automatic test_directed();
        send_item(tsoe_pkg::CMD_CLEAR, '0, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, VAL_MAX, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, VAL_MIN, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, 64'd0, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, 64'd4, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, 64'd5, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, -64'sd1, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, -64'sd5, 1'b0);
        send_item(CMD_IGNORED, {$urandom, $urandom}, 1'b1);
        send_item(tsoe_pkg::CMD_OPERAND, 64'd3, 1'b1);

        write_reg(tsoe_pkg::REG_OP_MODE, tsoe_pkg::TOL_W'(tsoe_pkg::MODE_INTERSECTION));
        write_reg(tsoe_pkg::REG_TOLERANCE, tsoe_pkg::TOL_W'(1));
        send_item(tsoe_pkg::CMD_CLEAR, '0, 1'b0);
        send_item(tsoe_pkg::CMD_LOAD, 64'd100, 1'b0);
        send_item(tsoe_pkg::CMD_LOAD, VAL_MIN, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, 64'd100, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, 64'd101, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, VAL_MIN, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, VAL_MAX, 1'b1);

        // With a zero tolerance nothing matches, so a repeated value is kept twice.
        write_reg(tsoe_pkg::REG_OP_MODE, tsoe_pkg::TOL_W'(tsoe_pkg::MODE_DIFFERENCE));
        write_reg(tsoe_pkg::REG_TOLERANCE, tsoe_pkg::TOL_W'(0));
        send_item(tsoe_pkg::CMD_OPERAND, 64'd7, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, 64'd7, 1'b1);

        write_reg(tsoe_pkg::REG_OP_MODE, tsoe_pkg::TOL_W'(MODE_UNUSED));
        send_item(tsoe_pkg::CMD_OPERAND, 64'd9, 1'b1);
    endtask

    task automatic test_reference_overflow();
        write_reg(tsoe_pkg::REG_OP_MODE, tsoe_pkg::TOL_W'(tsoe_pkg::MODE_INTERSECTION));
        write_reg(tsoe_pkg::REG_TOLERANCE, tsoe_pkg::TOL_W'(1));
        send_item(tsoe_pkg::CMD_CLEAR, '0, 1'($urandom_range(0, 1)));
        for (int i = 0; i < tsoe_pkg::REFERENCE_DEPTH + 2; i++)
            send_item(tsoe_pkg::CMD_LOAD, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        for (int i = 0; i < 4; i++)
            send_item(tsoe_pkg::CMD_OPERAND, pick_value(), 1'(i == 3));
        send_item(tsoe_pkg::CMD_CLEAR, '0, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, pick_value(), 1'b1);
    endtask

    task automatic test_result_overflow();
        write_reg(tsoe_pkg::REG_OP_MODE, tsoe_pkg::TOL_W'(tsoe_pkg::MODE_UNION));
        write_reg(tsoe_pkg::REG_TOLERANCE, tsoe_pkg::TOL_W'(1));
        send_item(tsoe_pkg::CMD_CLEAR, '0, 1'b0);
        for (int i = 0; i < tsoe_pkg::RESULT_DEPTH + 2; i++)
            send_item(tsoe_pkg::CMD_OPERAND, {$urandom, $urandom},
                      1'(i == tsoe_pkg::RESULT_DEPTH + 1));
        send_item(tsoe_pkg::CMD_OPERAND,
                  value_pool[$urandom_range(0, value_pool.size() - 1)], 1'b1);
        send_item(tsoe_pkg::CMD_CLEAR, '0, 1'b0);
        send_item(tsoe_pkg::CMD_OPERAND, {$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_random_phases();
        logic [1:0]                 mode;
        logic [tsoe_pkg::TOL_W-1:0] tol;
        int                         pick;
        int                         n_loads;
        int                         n_ops;
        bit                         drop_last;
        for (int phase = 0; phase < 14; phase++) begin
            mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            pick = (phase < 5) ? phase : $urandom_range(0, 7);
            case (pick)
                0:       tol = '0;
                1:       tol = tsoe_pkg::TOL_W'(1);
                2:       tol = tsoe_pkg::TOL_RESET;
                3:       tol = 33'h1_0000_0000;
                4:       tol = '1;
                5:       tol = tsoe_pkg::TOL_W'($urandom_range(0, 1000));
                default: tol = {1'($urandom_range(0, 1)), $urandom};
            endcase
            write_reg(tsoe_pkg::REG_OP_MODE, tsoe_pkg::TOL_W'(mode));
            write_reg(tsoe_pkg::REG_TOLERANCE, tol);
            src_no_gaps   = ($urandom_range(0, 3) == 0);
            sink_no_stall = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
                send_item(tsoe_pkg::CMD_CLEAR, '0, 1'($urandom_range(0, 1)));
            n_loads   = $urandom_range(0, 12);
            n_ops     = $urandom_range(1, 14);
            drop_last = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < n_loads; i++)
                send_item(tsoe_pkg::CMD_LOAD, pick_value(), 1'($urandom_range(0, 1)));
            for (int i = 0; i < n_ops; i++) begin
                if ($urandom_range(0, 99) < 8)
                    send_item(CMD_IGNORED, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 99) < 5)
                    send_item(tsoe_pkg::CMD_LOAD, pick_value(), 1'b0);
                send_item(tsoe_pkg::CMD_OPERAND, pick_value(),
                          (i == n_ops - 1) ? !drop_last : ($urandom_range(0, 19) == 0));
            end
        end
        src_no_gaps   = 1'b0;
        sink_no_stall = 1'b0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = tsoe_pkg::REG_OP_MODE;
        cfg_data       = '0;
        src_no_gaps    = 1'b0;
        sink_no_stall  = 1'b0;
        mismatch_count = 0;
        mode_reg       = tsoe_pkg::MODE_UNION;
        tol_reg        = tsoe_pkg::TOL_RESET;
        ref_count      = 0;
        set_count      = 0;
        overflow_flag  = 1'b0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_reference_overflow();
        test_result_overflow();
        test_random_phases();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (int k = 0; k < 5000 && expected_set_results.size() != 0; k++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_set_results.size() != 0)
            report_mismatch("results never delivered", 64'(expected_set_results.size()), '0);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
